/* hdl/pec_pkg.sv */
package pec_pkg;

  // Field widths of the item channels
  localparam int SIZE_W  = 3;
  localparam int COUNT_W = 17;

  // Default grid size limits
  localparam int DEF_MAX_ROWS = 4;
  localparam int DEF_MAX_COLS = 4;

  // Input item: requested grid size
  typedef struct packed {
    logic [SIZE_W-1:0] row_count;
    logic [SIZE_W-1:0] col_count;
  } pec_in_t;

  // Result item: percolating grids and grids examined
  typedef struct packed {
    logic [COUNT_W-1:0] percolating_count;
    logic [COUNT_W-1:0] grid_total;
  } pec_out_t;

endpackage

/* hdl/percolation_exhaustive_counter_core.sv */
// Exhaustive percolation counter.
// Pulse start with a grid size on in_item (row_count, col_count) while busy is
// low; a size of zero counts as one and a size above the maximum is clamped.
// The block then walks every binary grid of that size and, one row per cycle,
// carries the reachable set from the top row downward through a shared row
// unit that spreads reach sideways through runs of open cells. A grid ends
// early once nothing is reachable.
// busy stays high for the whole run. The result (percolating_count,
// grid_total, both modulo 2^17) shows on out_item for exactly one cycle with
// out_valid high; the receiver cannot stall and must take it then. A new
// start may be given in that same cycle.
// Reset (rst_n low, synchronous) drops any run in progress and clears busy
// and out_valid.
module percolation_exhaustive_counter_core #(
  parameter int MAX_ROWS = pec_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = pec_pkg::DEF_MAX_COLS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  pec_pkg::pec_in_t  in_item,
  output logic             out_valid,
  output pec_pkg::pec_out_t out_item
);

  localparam int SW        = pec_pkg::SIZE_W;
  localparam int CW        = pec_pkg::COUNT_W;
  localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;
  localparam int CELLS_W   = $clog2(MAX_CELLS + 1);
  localparam logic [SW-1:0] MAX_ROWS_V = SW'(MAX_ROWS);
  localparam logic [SW-1:0] MAX_COLS_V = SW'(MAX_COLS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_r, state_nxt;
  logic [SW-1:0]        rows_r, rows_nxt;
  logic [SW-1:0]        cols_r, cols_nxt;
  logic [SW-1:0]        row_idx_r, row_idx_nxt;
  logic [MAX_COLS-1:0]  row_mask_r, row_mask_nxt;
  logic [MAX_CELLS-1:0] cells_mask_r, cells_mask_nxt;
  logic [MAX_CELLS-1:0] grid_r, grid_nxt;
  logic [MAX_CELLS-1:0] grid_sh_r, grid_sh_nxt;
  logic [MAX_COLS-1:0]  reach_r, reach_nxt;
  logic [CW-1:0]        hits_r, hits_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pec_pkg::pec_out_t    out_item_r, out_item_nxt;

  logic [SW-1:0]        rows_cl, cols_cl;
  logic [5:0]           cells_prod;
  logic [CELLS_W-1:0]   cells;
  logic [MAX_COLS-1:0]  open_row, reach_in, reach_new;
  logic                 last_row, grid_end, last_grid;
  logic [CW-1:0]        hits_inc;

  // Clamp the requested size; the masks and grid total derive from it below
  always_comb begin
    if (in_item.row_count == '0) rows_cl = SW'(1);
    else if (in_item.row_count > MAX_ROWS_V) rows_cl = MAX_ROWS_V;
    else rows_cl = in_item.row_count;
    if (in_item.col_count == '0) cols_cl = SW'(1);
    else if (in_item.col_count > MAX_COLS_V) cols_cl = MAX_COLS_V;
    else cols_cl = in_item.col_count;
  end

  assign cells_prod = 6'(rows_cl) * 6'(cols_cl);
  assign cells      = CELLS_W'(cells_prod);

  // Shared row step
  assign open_row = grid_sh_r[MAX_COLS-1:0] & row_mask_r;
  assign reach_in = (row_idx_r == '0) ? row_mask_r : reach_r;

  pec_row_unit #(
    .MAX_COLS (MAX_COLS)
  ) u_row (
    .reach_in  (reach_in),
    .open_in   (open_row),
    .reach_out (reach_new)
  );

  assign last_row  = (row_idx_r == rows_r - SW'(1));
  assign grid_end  = last_row || (reach_new == '0);
  assign last_grid = ((grid_r & cells_mask_r) == cells_mask_r);
  assign hits_inc  = hits_r + CW'(reach_new != '0);

  // Sequence rows within a grid and grids within an item
  always_comb begin
    state_nxt      = state_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    row_idx_nxt    = row_idx_r;
    row_mask_nxt   = row_mask_r;
    cells_mask_nxt = cells_mask_r;
    grid_nxt       = grid_r;
    grid_sh_nxt    = grid_sh_r;
    reach_nxt      = reach_r;
    hits_nxt       = hits_r;
    total_nxt      = total_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt      = ST_RUN;
          rows_nxt       = rows_cl;
          cols_nxt       = cols_cl;
          row_idx_nxt    = '0;
          row_mask_nxt   = ~({MAX_COLS{1'b1}} << cols_cl);
          cells_mask_nxt = ~({MAX_CELLS{1'b1}} << cells);
          grid_nxt       = '0;
          grid_sh_nxt    = '0;
          reach_nxt      = '0;
          hits_nxt       = '0;
          total_nxt      = (cells_prod < 6'(CW)) ? (CW'(1) << cells_prod) : '0;
        end
      end
      ST_RUN: begin
        if (grid_end) begin
          hits_nxt    = hits_inc;
          row_idx_nxt = '0;
          if (last_grid) begin
            // finish the item and present the result
            state_nxt                      = ST_IDLE;
            out_valid_nxt                  = 1'b1;
            out_item_nxt.percolating_count = hits_inc;
            out_item_nxt.grid_total        = total_r;
          end else begin
            grid_nxt    = grid_r + MAX_CELLS'(1);
            grid_sh_nxt = grid_r + MAX_CELLS'(1);
          end
        end else begin
          // advance to the next row
          row_idx_nxt = row_idx_r + SW'(1);
          reach_nxt   = reach_new;
          grid_sh_nxt = grid_sh_r >> cols_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rows_r       <= rows_nxt;
    cols_r       <= cols_nxt;
    row_idx_r    <= row_idx_nxt;
    row_mask_r   <= row_mask_nxt;
    cells_mask_r <= cells_mask_nxt;
    grid_r       <= grid_nxt;
    grid_sh_r    <= grid_sh_nxt;
    reach_r      <= reach_nxt;
    hits_r       <= hits_nxt;
    total_r      <= total_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign busy      = (state_r == ST_RUN);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start a run");

  a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding run");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.grid_total != '0)) |->
      (out_item.percolating_count <= out_item.grid_total))
    else $error("percolating count exceeds grid total");
`endif

endmodule

/* hdl/pec_row_unit.sv */
module pec_row_unit #(
  parameter int MAX_COLS = pec_pkg::DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0] reach_in,
  input  logic [MAX_COLS-1:0] open_in,
  output logic [MAX_COLS-1:0] reach_out
);

  // Carry reach down into the open cells, then widen it sideways through
  // runs of open cells; MAX_COLS passes cover the longest run.
  always_comb begin
    logic [MAX_COLS-1:0] r;
    r = reach_in & open_in;
    for (int k = 0; k < MAX_COLS; k++) begin
      r = r | (((r << 1) | (r >> 1)) & open_in);
    end
    reach_out = r;
  end

endmodule

/* sim/testbench.sv */
module testbench;

  localparam int SIZE_W         = pec_pkg::SIZE_W;
  localparam int COUNT_W        = pec_pkg::COUNT_W;
  localparam int MAX_ROWS       = pec_pkg::DEF_MAX_ROWS;
  localparam int MAX_COLS       = pec_pkg::DEF_MAX_COLS;
  localparam int SMALL_CELLS    = 8;
  localparam int RANDOM_BIG_MAX = 3;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 5_000_000;

  typedef bit [MAX_COLS-1:0] row_bits_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pec_pkg::pec_in_t  in_item;
  logic              out_valid;
  pec_pkg::pec_out_t out_item;

  pec_pkg::pec_out_t expected_counts[$];
  int                error_count;
  int                sender_idle_pct;
  int                big_grid_count;
  int                cycles;

  percolation_exhaustive_counter_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Map a raw size field onto 1..limit
  function automatic int clamp_dim(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return int'(raw);
  endfunction

  // Widen reach sideways through runs of open cells in one row
  function automatic row_bits_t spread_open_run(input row_bits_t reach, input row_bits_t open,
                                                input int cols);
    row_bits_t r;
    r = reach;
    for (int k = 0; k < cols; k++) r |= ((r << 1) | (r >> 1)) & open;
    return r;
  endfunction

  // Enumerate every grid of the requested size and count the percolating ones
  function automatic pec_pkg::pec_out_t count_percolating_grids(input pec_pkg::pec_in_t size);
    int                rows;
    int                cols;
    int                total;
    int                hits;
    int                row_mask;
    row_bits_t         reach;
    row_bits_t         open;
    pec_pkg::pec_out_t res;
    rows     = clamp_dim(size.row_count, MAX_ROWS);
    cols     = clamp_dim(size.col_count, MAX_COLS);
    total    = 1 << (rows * cols);
    row_mask = (1 << cols) - 1;
    hits     = 0;
    for (int g = 0; g < total; g++) begin
      reach = row_bits_t'(g & row_mask);
      reach = spread_open_run(reach, reach, cols);
      for (int r = 1; r < rows && reach != 0; r++) begin
        open  = row_bits_t'((g >> (r * cols)) & row_mask);
        reach = spread_open_run(reach & open, open, cols);
      end
      if (reach != 0) hits++;
    end
    res.percolating_count = hits[COUNT_W-1:0];
    res.grid_total        = total[COUNT_W-1:0];
    return res;
  endfunction

  // Offer one size after a random gap; hold start until the block takes it
  task automatic send_size(input pec_pkg::pec_in_t size);
    while ($urandom_range(99) < sender_idle_pct) begin
      start   <= 1'b0;
      in_item <= pec_pkg::pec_in_t'($urandom);
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= size;
    do @(posedge clk); while (busy);
    expected_counts = {expected_counts, count_percolating_grids(size)};
    @(negedge clk);
  endtask

  function automatic pec_pkg::pec_in_t make_size(input int rows, input int cols);
    pec_pkg::pec_in_t s;
    s.row_count = rows[SIZE_W-1:0];
    s.col_count = cols[SIZE_W-1:0];
    return s;
  endfunction

  // Smallest, largest and zero sizes
  task automatic test_size_extremes;
    send_size(make_size(0, 0));
    send_size(make_size(1, 1));
    send_size(make_size(0, 7));
    send_size(make_size(7, 0));
    send_size(make_size(4, 4));
  endtask

  // Sizes above the maximum fold down to it
  task automatic test_clamped_sizes;
    send_size(make_size(5, 2));
    send_size(make_size(2, 6));
    send_size(make_size(6, 3));
    send_size(make_size(3, 5));
  endtask

  // Every nominal shape but the full grid, which the extremes test covers
  task automatic test_every_shape;
    for (int r = 1; r <= MAX_ROWS; r++)
      for (int c = 1; c <= MAX_COLS; c++)
        if (!(r == MAX_ROWS && c == MAX_COLS)) send_size(make_size(r, c));
  endtask

  // Random sizes, mostly small grids with a rare large one
  task automatic test_random_sizes(input int idle_pct, input int n_items);
    pec_pkg::pec_in_t size;
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      size.row_count = SIZE_W'($urandom_range(7));
      size.col_count = SIZE_W'($urandom_range(7));
      if (big_grid_count < RANDOM_BIG_MAX && $urandom_range(24) == 0) begin
        big_grid_count++;
      end else begin
        while (clamp_dim(size.row_count, MAX_ROWS) * clamp_dim(size.col_count, MAX_COLS)
               > SMALL_CELLS) begin
          size.row_count = SIZE_W'($urandom_range(7));
          size.col_count = SIZE_W'($urandom_range(7));
        end
      end
      send_size(size);
    end
  endtask

  // Compare each result with the oldest outstanding expectation
  always @(posedge clk) begin
    pec_pkg::pec_out_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result: percolating %0d total %0d", $time,
                 out_item.percolating_count, out_item.grid_total);
        error_count++;
      end else begin
        exp_res = expected_counts.pop_front();
        if (out_item.percolating_count !== exp_res.percolating_count) begin
          $display("%0t: percolating_count mismatch: expected %0d actual %0d", $time,
                   exp_res.percolating_count, out_item.percolating_count);
          error_count++;
        end
        if (out_item.grid_total !== exp_res.grid_total) begin
          $display("%0t: grid_total mismatch: expected %0d actual %0d", $time,
                   exp_res.grid_total, out_item.grid_total);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    error_count     = 0;
    big_grid_count  = 0;
    sender_idle_pct = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 15;
    test_size_extremes();
    test_clamped_sizes();
    test_every_shape();
    test_random_sizes(15, 26);
    test_random_sizes(69, 25);
    test_random_sizes(0, 25);

    // Drop start and wait out the last result
    start <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
